FILE: hw/rtl/feistel_lai_massey_block_decrypt_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the block decryptor
// Immediate-consequence and next-cycle property wrappers, clocked on clk and
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FEISTEL_LAI_MASSEY_BLOCK_DECRYPT_MACROS_SVH
`define FEISTEL_LAI_MASSEY_BLOCK_DECRYPT_MACROS_SVH
`ifndef SYNTH
// hold cons in the same cycle as ante
`define FLMBD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flmbd assertion failed");
// hold cons in the cycle after ante
`define FLMBD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flmbd assertion failed");
`else
`define FLMBD_ASSERT_NOW(lbl, ante, cons)
`define FLMBD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: hw/rtl/flmbd_pkg.sv
// ----------------------------------------------------------------------------
// flmbd_pkg
// Shared constants and types of the block decryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package flmbd_pkg;

  localparam int ResDepth = 4;
  localparam int PtrW     = $clog2(ResDepth);
  localparam int CntW     = $clog2(ResDepth + 1);

  localparam int CfgAddrW = 4;
  localparam int CfgDataW = 64;

  // register index codes (paddr bit 3)
  localparam logic KeyIdx  = 1'b0;
  localparam logic SboxIdx = 1'b1;

  localparam logic [63:0] SboxReset = 64'hFEDCBA9876543210;
  localparam logic [2:0]  FullBytes = 3'd4;

  typedef struct packed {
    logic [31:0] plain_block;
    logic [2:0]  out_bytes;
    logic        last_of_run;
    logic        stealing_error;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic            room;
    logic [CntW-1:0] level;
  } fstat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/feistel_lai_massey_block_decrypt.sv
// ----------------------------------------------------------------------------
// feistel_lai_massey_block_decrypt
// Flow: a beat is held in the input register, then its results go to the result queue.
// Throughput: one input beat per cycle while the queue has room for two results,
//   one result beat per cycle while out_tready is high; the single output port
//   bounds the rate when beats cause two results.
// Reset: synchronous active-low rst_n clears the held block, the queue and
//   the config registers (key 0, identity S-box).
// ----------------------------------------------------------------------------
`default_nettype none
`include "feistel_lai_massey_block_decrypt_macros.svh"

module feistel_lai_massey_block_decrypt (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [39:0]                      in_tdata,  // [31:0] cipher_block, [34:32] valid_bytes
  input  wire logic                             in_tlast,  // message_end
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [39:0]                      out_tdata, // [31:0] plain_block, [34:32] out_bytes
  output logic                                  out_tlast, // last_of_run
  output logic                                  out_tuser, // stealing_error
  // config port
  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [flmbd_pkg::CfgAddrW-1:0]   cfg_paddr,
  input  wire logic [flmbd_pkg::CfgDataW-1:0]   cfg_pwdata,
  output logic      [flmbd_pkg::CfgDataW-1:0]   cfg_prdata,
  output logic                                  cfg_pready
);

  // --------------------------------------------------------------------------
  // Config registers: key at byte 0, S-box table at byte 8. Bit 3 of the
  // address selects the register.
  // --------------------------------------------------------------------------
  logic [31:0] cipher_key_r;
  logic [63:0] sbox_table_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cipher_key_r <= '0;
      sbox_table_r <= flmbd_pkg::SboxReset;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3])
        flmbd_pkg::KeyIdx:  cipher_key_r <= cfg_pwdata[31:0];
        flmbd_pkg::SboxIdx: sbox_table_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3])
      flmbd_pkg::KeyIdx:  cfg_prdata = {32'd0, cipher_key_r};
      flmbd_pkg::SboxIdx: cfg_prdata = sbox_table_r;
      default:            cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Input register. Advance when the queue has room for two results.
  // --------------------------------------------------------------------------
  logic        s1_valid_r, s1_valid_nxt;
  logic [31:0] s1_blk_r;
  logic [2:0]  s1_nb_r;
  logic        s1_end_r;
  logic        in_acc;
  logic        proc;

  flmbd_pkg::fstat_t fstat;

  assign proc      = s1_valid_r && fstat.room;
  assign in_tready = !s1_valid_r || proc;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (proc) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_blk_r <= in_tdata[31:0];
      s1_nb_r  <= in_tdata[34:32];
      s1_end_r <= in_tlast;
    end
  end

  // --------------------------------------------------------------------------
  // Held block and ciphertext stealing. A partial beat borrows the low bytes
  // of the held plaintext, then releases the held block's top bytes.
  // --------------------------------------------------------------------------
  logic        held_valid_r, held_valid_nxt;
  logic [31:0] held_plain_r, held_plain_nxt;
  logic        is_zero, is_full, is_part;
  logic [31:0] top_mask;
  logic [31:0] dec_in, dec_out;

  assign is_zero = (s1_nb_r == 3'd0);
  assign is_full = s1_nb_r[2];
  assign is_part = !is_zero && !is_full;

  always_comb begin
    case (s1_nb_r[1:0])
      2'd1:    top_mask = 32'hFF00_0000;
      2'd2:    top_mask = 32'hFFFF_0000;
      2'd3:    top_mask = 32'hFFFF_FF00;
      default: top_mask = 32'h0000_0000;
    endcase
  end

  assign dec_in = is_part ? ((s1_blk_r & top_mask) | (held_plain_r & ~top_mask)) : s1_blk_r;

  flmbd_decrypt u_dec (
    .cipher_word (dec_in),
    .cipher_key  (cipher_key_r),
    .sbox_table  (sbox_table_r),
    .plain_word  (dec_out)
  );

  // --------------------------------------------------------------------------
  // Build up to two results per processed beat; mark the last one.
  // --------------------------------------------------------------------------
  flmbd_pkg::push_t push;

  always_comb begin
    push           = '0;
    held_valid_nxt = held_valid_r;
    held_plain_nxt = held_plain_r;
    if (proc) begin
      if (is_zero) begin
        if (s1_end_r && held_valid_r) begin
          push.num               = 2'd1;
          push.r0.plain_block    = held_plain_r;
          push.r0.out_bytes      = flmbd_pkg::FullBytes;
          push.r0.last_of_run    = 1'b1;
          held_valid_nxt         = 1'b0;
        end
      end else if (is_full) begin
        if (held_valid_r) begin
          push.num               = 2'd1;
          push.r0.plain_block    = held_plain_r;
          push.r0.out_bytes      = flmbd_pkg::FullBytes;
          if (s1_end_r) begin
            push.num             = 2'd2;
            push.r1.plain_block  = dec_out;
            push.r1.out_bytes    = flmbd_pkg::FullBytes;
            push.r1.last_of_run  = 1'b1;
          end else begin
            push.r0.last_of_run  = 1'b1;
          end
        end else if (s1_end_r) begin
          push.num               = 2'd1;
          push.r0.plain_block    = dec_out;
          push.r0.out_bytes      = flmbd_pkg::FullBytes;
          push.r0.last_of_run    = 1'b1;
        end
        if (s1_end_r) begin
          held_valid_nxt = 1'b0;
        end else begin
          held_valid_nxt = 1'b1;
          held_plain_nxt = dec_out;
        end
      end else if (!held_valid_r) begin
        // partial beat with nothing to steal from: flag and drop it
        push.num                 = 2'd1;
        push.r0.last_of_run      = 1'b1;
        push.r0.stealing_error   = 1'b1;
      end else begin
        push.num                 = 2'd2;
        push.r0.plain_block      = dec_out;
        push.r0.out_bytes        = flmbd_pkg::FullBytes;
        push.r1.plain_block      = held_plain_r & top_mask;
        push.r1.out_bytes        = s1_nb_r;
        push.r1.last_of_run      = 1'b1;
        held_valid_nxt           = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_plain_r <= held_plain_nxt;
  end

  // --------------------------------------------------------------------------
  // Result queue and output stream.
  // --------------------------------------------------------------------------
  flmbd_pkg::res_t head;
  logic            out_pop;

  assign out_pop = out_tvalid && out_tready;

  flmbd_res_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_pop),
    .head  (head),
    .stat  (fstat)
  );

  assign out_tvalid = (fstat.level != '0);
  assign out_tdata  = {5'd0, head.out_bytes, head.plain_block};
  assign out_tlast  = head.last_of_run;
  assign out_tuser  = head.stealing_error;

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  `FLMBD_ASSERT_NOW(a_level_bound, 1'b1, fstat.level <= flmbd_pkg::CntW'(flmbd_pkg::ResDepth))
  `FLMBD_ASSERT_NOW(a_err_shape, out_tvalid && out_tuser, out_tlast && (out_tdata[34:32] == 3'd0))
  `FLMBD_ASSERT_NEXT(a_steal_clears, proc && is_part && held_valid_r, !held_valid_r)

endmodule

`default_nettype wire

FILE: hw/rtl/flmbd_decrypt.sv
// ----------------------------------------------------------------------------
// flmbd_decrypt
// Two Feistel rounds, a half swap and two Lai-Massey rounds on one word.
// ----------------------------------------------------------------------------
`default_nettype none

module flmbd_decrypt (
  input  wire logic [31:0] cipher_word,
  input  wire logic [31:0] cipher_key,
  input  wire logic [63:0] sbox_table,
  output logic      [31:0] plain_word
);

  function automatic logic [3:0] sbox_sub(input logic [3:0] nib, input logic [63:0] tbl);
    return tbl[{nib, 2'b00} +: 4];
  endfunction

  // key xor, nibble substitution, bit i -> (5i+9) mod 16 counted from the top
  function automatic logic [15:0] round_f(input logic [15:0] x, input logic [15:0] k,
                                          input logic [63:0] tbl);
    logic [15:0] y;
    logic [15:0] s;
    logic [15:0] p;
    y = x ^ k;
    s = {sbox_sub(y[15:12], tbl), sbox_sub(y[11:8], tbl),
         sbox_sub(y[7:4], tbl), sbox_sub(y[3:0], tbl)};
    p = '0;
    for (int i = 0; i < 16; i++) begin
      p[15 - ((5 * i + 9) % 16)] = s[15 - i];
    end
    return p;
  endfunction

  logic [15:0] k0, k1;
  logic [15:0] l0, r0, l1, r1, l2, r2;
  logic [15:0] f3, l3, r3, f4, l4, r4;

  assign k0 = cipher_key[15:0];
  assign k1 = cipher_key[31:16];

  assign l0 = cipher_word[15:0];
  assign r0 = cipher_word[31:16];

  // Feistel rounds
  assign l1 = round_f(l0, k0, sbox_table) ^ r0;
  assign r1 = l0;
  assign l2 = round_f(l1, k1, sbox_table) ^ r1;
  assign r2 = l1;

  // swap halves, then Lai-Massey rounds
  assign f3 = round_f(r2 ^ l2, k0, sbox_table);
  assign l3 = r2 ^ f3;
  assign r3 = l2 ^ f3;
  assign f4 = round_f(l3 ^ r3, k1, sbox_table);
  assign l4 = l3 ^ f4;
  assign r4 = r3 ^ f4;

  assign plain_word = {l4, r4};

endmodule

`default_nettype wire

FILE: hw/rtl/flmbd_res_fifo.sv
// ----------------------------------------------------------------------------
// flmbd_res_fifo
// Small result queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module flmbd_res_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire flmbd_pkg::push_t      push,
  input  wire logic                  pop,
  output flmbd_pkg::res_t            head,
  output flmbd_pkg::fstat_t          stat
);

  flmbd_pkg::res_t mem_r [flmbd_pkg::ResDepth];

  logic [flmbd_pkg::PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [flmbd_pkg::PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [flmbd_pkg::CntW-1:0] cnt_r, cnt_nxt;
  logic [flmbd_pkg::PtrW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = wr_ptr_r + flmbd_pkg::PtrW'(1);

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.r0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.r1;
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + flmbd_pkg::PtrW'(push.num);
    rd_ptr_nxt = pop ? rd_ptr_r + flmbd_pkg::PtrW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + flmbd_pkg::CntW'(push.num) - flmbd_pkg::CntW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.level = cnt_r;
  assign stat.room  = (cnt_r <= flmbd_pkg::CntW'(flmbd_pkg::ResDepth - 2));

endmodule

`default_nettype wire

FILE: tb/flmbd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flmbd_stream_checker
// Watches the ciphertext and plaintext streams of the block decryptor. It
// mirrors the config writes, predicts the plaintext beats of every accepted
// ciphertext beat and compares them in order with the result stream.
// ----------------------------------------------------------------------------
module flmbd_stream_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [39:0]                    in_tdata,  // [31:0] cipher_block, [34:32] valid_bytes
  input  logic                           in_tlast,  // message_end
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [39:0]                    out_tdata, // [31:0] plain_block, [34:32] out_bytes
  input  logic                           out_tlast, // last_of_run
  input  logic                           out_tuser, // stealing_error
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [flmbd_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [flmbd_pkg::CfgDataW-1:0] cfg_pwdata,
  input  logic                           cfg_pready,
  output int                             fail_count,
  output int                             pending
);

  logic [31:0]     key_cfg;
  logic [63:0]     sbox_cfg;
  logic [31:0]     held_word;
  logic            held_live;
  int              mismatches = 0;
  flmbd_pkg::res_t plain_due[$];

  // Key XOR, nibble substitution, then bit i (MSB first) moves to (5i+9) mod 16.
  function automatic logic [15:0] mix16(input logic [15:0] x, input logic [15:0] k);
    logic [15:0] y;
    logic [15:0] s;
    logic [15:0] p;
    int          np;
    y = x ^ k;
    for (int j = 0; j < 4; j++) s[4*j +: 4] = sbox_cfg[4*y[4*j +: 4] +: 4];
    p = '0;
    for (int i = 0; i < 16; i++) begin
      np = (5 * i + 9) % 16;
      p[15-np] = s[15-i];
    end
    return p;
  endfunction

  function automatic logic [31:0] decrypt_block(input logic [31:0] blk);
    logic [15:0] lh;
    logic [15:0] rh;
    logic [15:0] t;
    logic [15:0] ks [2];
    ks[0] = key_cfg[15:0];
    ks[1] = key_cfg[31:16];
    lh = blk[15:0];
    rh = blk[31:16];
    for (int i = 0; i < 2; i++) begin
      t  = mix16(lh, ks[i]) ^ rh;
      rh = lh;
      lh = t;
    end
    t  = lh;
    lh = rh;
    rh = t;
    for (int i = 0; i < 2; i++) begin
      t  = mix16(lh ^ rh, ks[i]);
      lh = lh ^ t;
      rh = rh ^ t;
    end
    return {lh, rh};
  endfunction

  function automatic flmbd_pkg::res_t make_res(input logic [31:0] pb, input logic [2:0] nb,
                                               input logic err);
    flmbd_pkg::res_t r;
    r.plain_block    = pb;
    r.out_bytes      = nb;
    r.last_of_run    = 1'b0;
    r.stealing_error = err;
    return r;
  endfunction

  task automatic run_beat(input logic [31:0] blk, input logic [2:0] nb, input logic msg_end);
    flmbd_pkg::res_t outs [2];
    int              n;
    logic [31:0]     top_mask;
    logic [31:0]     word;
    n = 0;
    if (nb == 3'd0) begin
      if (msg_end && held_live) begin
        outs[n] = make_res(held_word, flmbd_pkg::FullBytes, 1'b0);
        n++;
        held_live = 1'b0;
        held_word = '0;
      end
    end else if (nb >= flmbd_pkg::FullBytes) begin
      word = decrypt_block(blk);
      if (held_live) begin
        outs[n] = make_res(held_word, flmbd_pkg::FullBytes, 1'b0);
        n++;
      end
      if (msg_end) begin
        outs[n] = make_res(word, flmbd_pkg::FullBytes, 1'b0);
        n++;
        held_live = 1'b0;
        held_word = '0;
      end else begin
        held_word = word;
        held_live = 1'b1;
      end
    end else if (!held_live) begin
      outs[n] = make_res('0, 3'd0, 1'b1);
      n++;
    end else begin
      // steal the low bytes of the held block to fill the short one
      top_mask = 32'hFFFF_FFFF << ((4 - nb) * 8);
      word     = decrypt_block((blk & top_mask) | (held_word & ~top_mask));
      outs[0]  = make_res(word, flmbd_pkg::FullBytes, 1'b0);
      outs[1]  = make_res(held_word & top_mask, nb, 1'b0);
      n = 2;
      held_live = 1'b0;
      held_word = '0;
    end
    if (n > 0) outs[n-1].last_of_run = 1'b1;
    for (int i = 0; i < n; i++) plain_due.push_back(outs[i]);
  endtask

  task automatic check_beat();
    flmbd_pkg::res_t want;
    if (plain_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected result beat: tdata %h last %b err %b",
                 $realtime, out_tdata, out_tlast, out_tuser);
    end else begin
      want = plain_due.pop_front();
      if (out_tdata !== {5'b0, want.out_bytes, want.plain_block} ||
          out_tlast !== want.last_of_run || out_tuser !== want.stealing_error) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result mismatch: expected plain %h bytes %0d last %b err %b, got %s",
                   $realtime, want.plain_block, want.out_bytes, want.last_of_run,
                   want.stealing_error,
                   $sformatf("plain %h bytes %0d last %b err %b (upper tdata %b)",
                             out_tdata[31:0], out_tdata[34:32], out_tlast, out_tuser,
                             out_tdata[39:35]));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      key_cfg   = '0;
      sbox_cfg  = flmbd_pkg::SboxReset;
      held_word = '0;
      held_live = 1'b0;
      plain_due.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        if (cfg_paddr[3] == flmbd_pkg::SboxIdx) sbox_cfg = cfg_pwdata;
        else key_cfg = cfg_pwdata[31:0];
      end
      if (out_tvalid && out_tready) check_beat();
      if (in_tvalid && in_tready) run_beat(in_tdata[31:0], in_tdata[34:32], in_tlast);
    end
    fail_count <= mismatches;
    pending    <= plain_due.size();
  end

endmodule

FILE: tb/tb_feistel_lai_massey_block_decrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_feistel_lai_massey_block_decrypt
// Drives ciphertext beats into the block decryptor: a directed set covering
// full, partial, empty and error blocks, then random messages and noise over
// several key and S-box settings, with bursty input and a stalling receiver.
// The stream checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_feistel_lai_massey_block_decrypt;

  localparam int CycleLimit  = 1_000_000;
  localparam int DirectedCnt = 24;
  localparam int RandomItems = 1750;
  localparam int NumPhases   = 6;

  logic                           clk;
  logic                           rst_n       = 1'b0;
  logic                           in_tvalid   = 1'b0;
  logic                           in_tready;
  logic [39:0]                    in_tdata    = '0;  // [31:0] cipher_block, [34:32] valid_bytes
  logic                           in_tlast    = 1'b0; // message_end
  logic                           out_tvalid;
  logic                           out_tready  = 1'b0;
  logic [39:0]                    out_tdata;          // [31:0] plain_block, [34:32] out_bytes
  logic                           out_tlast;          // last_of_run
  logic                           out_tuser;          // stealing_error
  logic                           cfg_psel    = 1'b0;
  logic                           cfg_penable = 1'b0;
  logic                           cfg_pwrite  = 1'b0;
  logic [flmbd_pkg::CfgAddrW-1:0] cfg_paddr   = '0;
  logic [flmbd_pkg::CfgDataW-1:0] cfg_pwdata  = '0;
  logic [flmbd_pkg::CfgDataW-1:0] cfg_prdata;
  logic                           cfg_pready;

  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   items_sent  = 0;
  int   burst_left  = 0;
  int   stall_cyc   = 0;
  int   stall_hold  = 0;
  logic rx_flush    = 1'b0;

  feistel_lai_massey_block_decrypt uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  flmbd_stream_checker flow_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: no correct run gets near this many cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: the stall mode is taken from bits 9:8 of a free-running counter. Mode 0 never stalls,
  // mode 1 drops ready at random, mode 2 follows a fixed duty pattern and
  // mode 3 holds off for long stretches. Hold ready high for the final drain.
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (rx_flush) begin
      out_tready <= 1'b1;
    end else begin
      case (stall_cyc[9:8])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ($urandom_range(0, 3) != 0);
        2'd2: out_tready <= ((stall_cyc % 7) >= 3);
        default: begin
          if (stall_hold > 0) begin
            out_tready <= 1'b0;
            stall_hold <= stall_hold - 1;
          end else if ($urandom_range(0, 7) == 0) begin
            out_tready <= 1'b0;
            stall_hold <= $urandom_range(4, 24);
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Present one ciphertext beat and hold it until accepted. Bursts of random
  // length are separated by random gaps; a gap of zero keeps the stream solid.
  task automatic push_beat(input logic [31:0] blk, input logic [2:0] nb, input logic msg_end);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, nb, blk};
    in_tlast  <= msg_end;
    do @(posedge clk); while (!in_tready);
    burst_left--;
    items_sent++;
  endtask

  // Drop valid, wait until every predicted beat has come out, then let the clock
  // run on in case a beat with no result is still in flight.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup phase, access phase until pready, then back to idle.
  task automatic cfg_write(input logic idx, input logic [flmbd_pkg::CfgDataW-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 3'b000};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly random words, with all-zero and all-one blocks mixed in.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Byte counts above four also count as a full block; use them now and then.
  function automatic logic [2:0] full_count();
    if ($urandom_range(0, 15) == 0) return 3'($urandom_range(5, 7));
    return flmbd_pkg::FullBytes;
  endfunction

  // One message: some full blocks, then an ending that is a full block with the
  // end mark, a partial block (stolen, or an error if nothing is held), an empty
  // flush beat, or nothing at all so that the next message flushes the held block.
  task automatic send_message();
    int          nfull;
    logic [2:0]  r;
    logic [31:0] w;
    nfull = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
    for (int i = 0; i < nfull; i++) push_beat(pick_word(), full_count(), 1'b0);
    case ($urandom_range(0, 3))
      0: push_beat(pick_word(), full_count(), 1'b1);
      1: begin
        r = 3'($urandom_range(1, 3));
        w = pick_word();
        // keep the unused low bytes zero most of the time
        if ($urandom_range(0, 4) != 0) w = w & (32'hFFFF_FFFF << ((4 - r) * 8));
        push_beat(w, r, 1'($urandom_range(0, 1)));
      end
      2: push_beat(pick_word(), 3'd0, 1'b1);
      default: ;
    endcase
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats under the reset config (zero key, identity S-box).
    push_beat(32'h0000_0000, flmbd_pkg::FullBytes, 1'b0);  // hold first block, no result
    push_beat(32'hFFFF_FFFF, flmbd_pkg::FullBytes, 1'b1);  // held block plus the new one
    push_beat(32'hAB00_0000, 3'd1, 1'b0);       // partial with nothing held: error
    push_beat(32'h0000_0000, 3'd0, 1'b1);       // empty end beat, nothing to flush
    push_beat(32'h1234_5678, flmbd_pkg::FullBytes, 1'b0);
    push_beat(32'hFFFF_FFFF, 3'd0, 1'b0);       // empty beat without end: ignored
    push_beat(32'h0000_0000, 3'd0, 1'b1);       // empty end beat flushes held block
    push_beat(32'hA5A5_A5A5, flmbd_pkg::FullBytes, 1'b0);
    push_beat(32'hDEAD_BE00, 3'd3, 1'b1);       // steal one byte
    push_beat(32'h0F1E_2D3C, flmbd_pkg::FullBytes, 1'b0);
    push_beat(32'hFFFF_0000, 3'd2, 1'b0);       // steal two bytes, end mark low
    push_beat(32'h8000_0000, flmbd_pkg::FullBytes, 1'b0);
    push_beat(32'h7F6E_5D4C, 3'd1, 1'b1);       // steal three, junk in unused bytes
    push_beat(32'h1357_9BDF, 3'd5, 1'b0);       // oversized byte counts act as full
    push_beat(32'h2468_ACE0, 3'd6, 1'b0);
    push_beat(32'hFFFF_FFFF, 3'd7, 1'b1);
    push_beat(32'h0000_0000, 3'd3, 1'b0);       // error again
    push_beat(32'hFFFF_FF00, 3'd2, 1'b1);       // error with end mark
    push_beat(32'hC3C3_C3C3, flmbd_pkg::FullBytes, 1'b0);
    push_beat(32'h3C3C_3C3C, flmbd_pkg::FullBytes, 1'b0);
    push_beat(32'h00FF_00FF, flmbd_pkg::FullBytes, 1'b0);
    push_beat(32'hFF00_FF00, flmbd_pkg::FullBytes, 1'b1);
    push_beat(32'hFFFF_FFFF, flmbd_pkg::FullBytes, 1'b0);
    push_beat(32'hFFFF_FF00, 3'd3, 1'b0);

    // Random phases, each under its own key and S-box.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      case (p)
        0: begin
          cfg_write(flmbd_pkg::KeyIdx, 64'hFFFF_FFFF);
          cfg_write(flmbd_pkg::SboxIdx, 64'h0);
        end
        1: begin
          cfg_write(flmbd_pkg::KeyIdx, 64'($urandom()));
          cfg_write(flmbd_pkg::SboxIdx, 64'hFFFF_FFFF_FFFF_FFFF);
        end
        3: begin
          cfg_write(flmbd_pkg::KeyIdx, 64'h0);
          cfg_write(flmbd_pkg::SboxIdx, flmbd_pkg::SboxReset);
        end
        4: begin
          cfg_write(flmbd_pkg::KeyIdx, 64'h0000_FFFF);
          cfg_write(flmbd_pkg::SboxIdx, {32'($urandom()), 32'($urandom())});
        end
        default: begin
          cfg_write(flmbd_pkg::KeyIdx, 64'($urandom()));
          cfg_write(flmbd_pkg::SboxIdx, {32'($urandom()), 32'($urandom())});
        end
      endcase
      while (items_sent < DirectedCnt + (p + 1) * RandomItems / NumPhases) begin
        if ($urandom_range(0, 4) != 0) send_message();
        else push_beat($urandom(), 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
      end
    end

    // Drain with the receiver always ready, then let the block sit idle.
    rx_flush <= 1'b1;
    settle();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
